### sv/utf8_stream_decoder_unit_defines.svh
// ---------------------------------------------------------------------------
// utf8_stream_decoder_unit_defines
// Assertion macros shared by the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

// check cons in the same cycle as ante
`define U8SD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define U8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/u8sd_pkg.sv
// ---------------------------------------------------------------------------
// u8sd_pkg
// Types, status codes and lead byte masks of the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8sd_pkg;

	localparam int unsigned CpWidth   = 31;
	localparam int unsigned PendWidth = 3;

	localparam logic [7:0] MaskLead0 = 8'h7F;
	localparam logic [7:0] MaskCont  = 8'h3F;
	localparam logic [7:0] MaskLead2 = 8'h1F;
	localparam logic [7:0] MaskLead3 = 8'h0F;
	localparam logic [7:0] MaskLead4 = 8'h07;
	localparam logic [7:0] MaskLead5 = 8'h03;
	localparam logic [7:0] MaskLead6 = 8'h01;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_STRAY    = 2'd1,
		ST_TRUNC    = 2'd2,
		ST_BAD_LEAD = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [CpWidth-1:0] code_point;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} emit_t;

endpackage

### sv/utf8_stream_decoder_unit.sv
// ---------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream to code point decoder, legacy 5- and 6-byte forms included.
//
//   channel  direction  payload                    results per word
//   in       sink       data_byte, end_of_text     -
//   out      source     code_point, status         zero or one per input word
//
// One byte word enters per cycle while in_stall is low; each byte passes the
// input register, then its result goes to the result register.
// The pending count and accumulator update once per byte that the decoder takes.
// Reset clears the pending count, accumulator and both valid flags.
// out_stall holds the result register; in_stall rises only while a result
// waits and the input register is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_stream_decoder_unit_defines.svh"

module utf8_stream_decoder_unit
	import u8sd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               end_of_text,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CpWidth-1:0] code_point,
	output logic [1:0]         status
);

	item_t   in_item, item_s1;
	logic    valid_s1, can_load, fire;
	emit_t   emit;
	result_t res_q;

	assign in_item.data_byte   = data_byte;
	assign in_item.end_of_text = end_of_text;
	assign fire                = valid_s1 && can_load;

	u8sd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (can_load),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	u8sd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.emit   (emit)
	);

	u8sd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.emit      (emit),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign code_point = res_q.code_point;
	assign status     = res_q.status;

	`U8SD_ASSERT_NOW(a_err_zero_cp, clk, arst_n, out_valid && (status != ST_OK), code_point == '0, "error result carries nonzero code point")
	`U8SD_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall && valid_s1, "input stalled without a waiting result")
	`U8SD_ASSERT_NEXT(a_fire_result, clk, arst_n, fire && emit.valid, out_valid, "emitted result not registered")

endmodule

### sv/u8sd_in_reg.sv
// ---------------------------------------------------------------------------
// u8sd_in_reg
// Input register: holds one byte word until the decoder takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8sd_in_reg
	import u8sd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load     = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### sv/u8sd_core.sv
// ---------------------------------------------------------------------------
// u8sd_core
// Decode state (pending count, accumulator) and the per-byte update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8sd_core
	import u8sd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  fire,
	input  item_t item,
	output emit_t emit
);

	logic [PendWidth-1:0] pend_q, pend_n, pend_dec;
	logic [CpWidth-1:0]   acc_q, acc_n, acc_shift;
	logic [7:0]           b;

	assign b         = item.data_byte;
	assign acc_shift = {acc_q[CpWidth-7:0], b[5:0] & MaskCont[5:0]};
	assign pend_dec  = pend_q - PendWidth'(1);

	always_comb begin
		pend_n               = pend_q;
		acc_n                = acc_q;
		emit.valid           = 1'b0;
		emit.res.code_point  = '0;
		emit.res.status      = ST_OK;
		if (item.end_of_text) begin
			if (pend_q != '0) begin
				pend_n          = '0;
				acc_n           = '0;
				emit.valid      = 1'b1;
				emit.res.status = ST_TRUNC;
			end
		end else if (pend_q == '0) begin
			case (b) inside
				[8'h00:8'h7F]: begin
					emit.valid          = 1'b1;
					emit.res.code_point = CpWidth'(b & MaskLead0);
				end
				[8'h80:8'hBF]: begin
					emit.valid      = 1'b1;
					emit.res.status = ST_STRAY;
				end
				[8'hC0:8'hDF]: begin
					acc_n  = CpWidth'(b & MaskLead2);
					pend_n = PendWidth'(1);
				end
				[8'hE0:8'hEF]: begin
					acc_n  = CpWidth'(b & MaskLead3);
					pend_n = PendWidth'(2);
				end
				[8'hF0:8'hF7]: begin
					acc_n  = CpWidth'(b & MaskLead4);
					pend_n = PendWidth'(3);
				end
				[8'hF8:8'hFB]: begin
					acc_n  = CpWidth'(b & MaskLead5);
					pend_n = PendWidth'(4);
				end
				[8'hFC:8'hFD]: begin
					acc_n  = CpWidth'(b & MaskLead6);
					pend_n = PendWidth'(5);
				end
				default: begin
					emit.valid      = 1'b1;
					emit.res.status = ST_BAD_LEAD;
				end
			endcase
		end else if (!b[7]) begin
			pend_n          = '0;
			acc_n           = '0;
			emit.valid      = 1'b1;
			emit.res.status = ST_TRUNC;
		end else begin
			pend_n = pend_dec;
			if (pend_dec == '0) begin
				acc_n               = '0;
				emit.valid          = 1'b1;
				emit.res.code_point = acc_shift;
			end else begin
				acc_n = acc_shift;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			acc_q  <= '0;
		end else if (fire) begin
			pend_q <= pend_n;
			acc_q  <= acc_n;
		end
	end

endmodule

### sv/u8sd_out_reg.sv
// ---------------------------------------------------------------------------
// u8sd_out_reg
// Result register: holds one decoded word until the sink takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8sd_out_reg
	import u8sd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  emit_t   emit,
	output logic    can_load,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t res_q
);

	assign can_load = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= fire && emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && fire && emit.valid) begin
			res_q <= emit.res;
		end
	end

endmodule

### bench/tb_utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_utf8_stream_decoder_unit
// Self-checking bench for the UTF-8 stream decoder. A short table of
// directed words (extremes, error codes, sequence lengths 1-3 and 6) is followed
// by randomly built text, mostly well-formed sequences with random payload,
// mixed with truncations, stray continuations and invalid lead bytes. Every
// accepted word runs through a behavioral decoder; results are compared in
// order with the DUT output, under random bursts, gaps and output stalls.
// ---------------------------------------------------------------------------

module tb_utf8_stream_decoder_unit;
	import u8sd_pkg::*;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_FIXED
	} chk_kind_t;

	typedef struct {
		logic [7:0]         data;
		logic               eot;
		chk_kind_t          kind;
		logic [CpWidth-1:0] cp;
		status_t            st;
	} text_word_t;

	localparam int NumRows     = 24;
	localparam int RandomWords = 900;
	localparam int HoldCycles  = 60;
	localparam int HoldAfter   = 150;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         data_byte;
	logic               end_of_text;
	logic               out_valid;
	logic               out_stall;
	logic [CpWidth-1:0] code_point;
	logic [1:0]         status;

	text_word_t text_q[$];
	result_t    decoded_q[$];
	text_word_t cur_word;

	logic [PendWidth-1:0] pend_cnt = '0;
	logic [CpWidth-1:0]   acc_bits = '0;

	bit in_took   = 0;
	bit feed_done = 0;
	bit hold_off  = 0;
	bit hold_done = 0;
	int burst_left;
	int gap_left;
	int errors       = 0;
	int words_taken  = 0;
	int results_seen = 0;
	int stall_cycles = 0;
	int status_seen[4] = '{0, 0, 0, 0};

	text_word_t dir_tab [NumRows] = '{
		'{8'hFF, 1'b1, CHK_NONE,  31'd0,     ST_OK},
		'{8'h00, 1'b0, CHK_FIXED, 31'd0,     ST_OK},
		'{8'h7F, 1'b0, CHK_FIXED, 31'h7F,    ST_OK},
		'{8'h80, 1'b0, CHK_FIXED, 31'd0,     ST_STRAY},
		'{8'hBF, 1'b0, CHK_FIXED, 31'd0,     ST_STRAY},
		'{8'hFE, 1'b0, CHK_FIXED, 31'd0,     ST_BAD_LEAD},
		'{8'hFF, 1'b0, CHK_FIXED, 31'd0,     ST_BAD_LEAD},
		'{8'hC2, 1'b0, CHK_NONE,  31'd0,     ST_OK},
		'{8'hA9, 1'b0, CHK_MODEL, 31'd0,     ST_OK},
		'{8'hE2, 1'b0, CHK_NONE,  31'd0,     ST_OK},
		'{8'h82, 1'b0, CHK_MODEL, 31'd0,     ST_OK},
		'{8'hAC, 1'b0, CHK_MODEL, 31'd0,     ST_OK},
		'{8'hFD, 1'b0, CHK_NONE,  31'd0,     ST_OK},
		'{8'hBF, 1'b0, CHK_NONE,  31'd0,     ST_OK},
		'{8'hBF, 1'b0, CHK_NONE,  31'd0,     ST_OK},
		'{8'hBF, 1'b0, CHK_NONE,  31'd0,     ST_OK},
		'{8'hBF, 1'b0, CHK_NONE,  31'd0,     ST_OK},
		'{8'hBF, 1'b0, CHK_FIXED, 31'h7FFFFFFF, ST_OK},
		'{8'hF8, 1'b0, CHK_NONE,  31'd0,     ST_OK},
		'{8'h41, 1'b0, CHK_FIXED, 31'd0,     ST_TRUNC},
		'{8'hE0, 1'b0, CHK_NONE,  31'd0,     ST_OK},
		'{8'h00, 1'b1, CHK_FIXED, 31'd0,     ST_TRUNC},
		'{8'hC0, 1'b0, CHK_NONE,  31'd0,     ST_OK},
		'{8'hFF, 1'b0, CHK_MODEL, 31'd0,     ST_OK}
	};

	utf8_stream_decoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void decode_byte(input logic [7:0] b, input logic eot,
			output bit has, output result_t r);
		int n;
		has = 0;
		r = '{code_point: '0, status: ST_OK};
		n = 0;
		if (eot) begin
			if (pend_cnt != 0) begin
				pend_cnt = '0;
				acc_bits = '0;
				has = 1;
				r.status = ST_TRUNC;
			end
			return;
		end
		if (pend_cnt == 0) begin
			while (n < 8 && b[7-n]) n++;
			case (n)
				0: begin
					has = 1;
					r.code_point = CpWidth'(b & MaskLead0);
				end
				1: begin
					has = 1;
					r.status = ST_STRAY;
				end
				2: acc_bits = CpWidth'(b & MaskLead2);
				3: acc_bits = CpWidth'(b & MaskLead3);
				4: acc_bits = CpWidth'(b & MaskLead4);
				5: acc_bits = CpWidth'(b & MaskLead5);
				6: acc_bits = CpWidth'(b & MaskLead6);
				default: begin
					has = 1;
					r.status = ST_BAD_LEAD;
				end
			endcase
			if (n >= 2 && n <= 6)
				pend_cnt = PendWidth'(n - 1);
		end else if (!b[7]) begin
			pend_cnt = '0;
			acc_bits = '0;
			has = 1;
			r.status = ST_TRUNC;
		end else begin
			acc_bits = {acc_bits[CpWidth-7:0], b[5:0] & MaskCont[5:0]};
			pend_cnt = pend_cnt - PendWidth'(1);
			if (pend_cnt == 0) begin
				has = 1;
				r.code_point = acc_bits;
				acc_bits = '0;
			end
		end
	endfunction

	function automatic void push_word(input logic [7:0] b, input logic eot);
		text_q.push_back('{b, eot, CHK_MODEL, '0, ST_OK});
	endfunction

	function automatic logic [7:0] lead_byte(input int n);
		logic [31:0] r;
		logic [7:0]  ones;
		r = $urandom;
		ones = 8'hFF << (8 - n);
		if (n == 1)
			return {1'b0, r[6:0]};
		return ones | (r[7:0] & (8'hFF >> (n + 1)));
	endfunction

	function automatic logic [7:0] cont_byte();
		logic [31:0] r;
		r = $urandom;
		if ($urandom_range(0, 19) == 0)
			return {2'b11, r[5:0]};
		return {2'b10, r[5:0]};
	endfunction

	function automatic int pick_len();
		int p;
		p = $urandom_range(0, 9);
		if (p < 8)
			return p / 2 + 1;
		return p - 3;
	endfunction

	task automatic build_random_text();
		int count;
		int choice;
		int len;
		int k;
		logic [31:0] r;
		count = 0;
		while (count < RandomWords) begin
			choice = $urandom_range(0, 99);
			r = $urandom;
			if (choice < 70) begin
				len = pick_len();
				push_word(lead_byte(len), r[8]);
				if (r[8]) len = 1;
				for (int i = 1; i < len; i++) push_word(cont_byte(), 1'b0);
				count += len;
			end else if (choice < 85) begin
				len = $urandom_range(2, 6);
				k = $urandom_range(0, len - 2);
				push_word(lead_byte(len), 1'b0);
				for (int i = 0; i < k; i++) push_word(cont_byte(), 1'b0);
				if (choice < 78)
					push_word({1'b0, r[6:0]}, 1'b0);
				else
					push_word(r[7:0], 1'b1);
				count += k + 2;
			end else begin
				if (choice < 90)
					push_word(r[7:0], 1'b1);
				else if (choice < 95)
					push_word({2'b10, r[5:0]}, 1'b0);
				else if (choice < 98)
					push_word({7'h7F, r[0]}, 1'b0);
				else
					push_word(r[7:0], 1'b0);
				count++;
			end
		end
	endtask

	always @(posedge clk) begin
		bit      has;
		result_t r;
		result_t want;
		if (arst_n) begin
			in_took = in_valid && !in_stall;
			if (in_valid && in_stall)
				stall_cycles++;
			if (in_took) begin
				words_taken++;
				decode_byte(cur_word.data, cur_word.eot, has, r);
				case (cur_word.kind)
					CHK_FIXED: decoded_q.push_back('{code_point: cur_word.cp,
						status: cur_word.st});
					CHK_MODEL: if (has) decoded_q.push_back(r);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				status_seen[status]++;
				if (decoded_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result code_point=%h status=%0d",
						$time, code_point, status);
				end else begin
					want = decoded_q.pop_front();
					if (code_point !== want.code_point) begin
						errors++;
						$display("%0t: code_point expected %h actual %h",
							$time, want.code_point, code_point);
					end
					if (status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
					end
				end
			end
		end
	end

	initial begin : feed
		in_valid = 1'b0;
		data_byte = 8'h00;
		end_of_text = 1'b0;
		burst_left = 0;
		gap_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!in_valid || in_took) begin
				if (text_q.size() == 0) begin
					in_valid = 1'b0;
					break;
				end
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
				if (burst_left > 0 || hold_off) begin
					cur_word = text_q.pop_front();
					data_byte = cur_word.data;
					end_of_text = cur_word.eot;
					in_valid = 1'b1;
					if (burst_left > 0)
						burst_left--;
				end else begin
					gap_left--;
					in_valid = 1'b0;
				end
			end
		end
		feed_done = 1;
	end

	initial begin : drain
		int mode;
		int mode_left;
		out_stall = 1'b0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HoldAfter) begin
				hold_off = 1;
				out_stall = 1'b1;
				repeat (HoldCycles) @(negedge clk);
				hold_off = 0;
				hold_done = 1;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			case (mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 3) == 0);
				2: out_stall = ($urandom_range(0, 3) != 0);
				default: out_stall = ~out_stall;
			endcase
		end
	end

	initial begin
		arst_n = 1'b0;
		for (int i = 0; i < NumRows; i++) text_q.push_back(dir_tab[i]);
		build_random_text();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (feed_done);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("run: %0d words decoded, %0d results (ok %0d, stray %0d, trunc %0d, bad lead %0d)",
			words_taken, results_seen, status_seen[0], status_seen[1], status_seen[2],
			status_seen[3]);
		$display("run: %0d cycles of input back-pressure, %0d-cycle output hold included",
			stall_cycles, HoldCycles);
		if (errors == 0)
			$display("utf8_stream_decoder_unit: match");
		else
			$display("utf8_stream_decoder_unit: mismatch");
		$finish;
	end

	initial begin
		#200000;
		$display("utf8_stream_decoder_unit: mismatch");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/u8sd_pkg.sv
sv/u8sd_in_reg.sv
sv/u8sd_core.sv
sv/u8sd_out_reg.sv
sv/utf8_stream_decoder_unit.sv
bench/tb_utf8_stream_decoder_unit.sv
